// ===== hdl/dtfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfx_pkg
// shared types and constants of the decimal text to fixed point unit
// ----------------------------------------------------------------------------
package dtfx_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_NO_DIGIT = 2'd2,
    ST_RANGE    = 2'd3
  } dtfx_status_e;

  // parser phase
  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_BODY  = 2'd2
  } dtfx_phase_e;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // place weights: 2^f / 10^k is zero from k = 15 on for every f up to 48
  localparam int NumPlaces = 16;
  localparam int PlaceIdxWidth = $clog2(NumPlaces);

  localparam logic [63:0] POW10 [NumPlaces] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000
  };

endpackage

// ===== hdl/dtfx_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfx channel interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dtfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface dtfx_out_if #(
  parameter int ValueWidth = 31
);
  logic                          valid;
  logic                          ready;
  logic signed [ValueWidth-1:0]  value;
  dtfx_pkg::dtfx_status_e        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hdl/dtfx_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfx_parse
// parser state and accumulators, one byte per step, result fields on nul
// ----------------------------------------------------------------------------
module dtfx_parse #(
  parameter int FracBits = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   ch_i,
  output logic signed [FracBits+2:0]   value_o,
  output dtfx_pkg::dtfx_status_e       status_o
);
  import dtfx_pkg::*;

  localparam int ValueWidth = FracBits + 3;
  localparam logic [63:0] OneFx = 64'd1 << FracBits;

  // truncated place weights, entry k = floor(2^f / 10^k) for k >= 1; entry 0 truncates to zero
  logic [FracBits-1:0] weight_tab [NumPlaces];

  for (genvar k = 0; k < NumPlaces; k++) begin : g_weight
    localparam logic [63:0] WeightK = OneFx / POW10[k];
    assign weight_tab[k] = WeightK[FracBits-1:0];
  end

  dtfx_phase_e              phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic                     point_q, point_d;
  logic                     digit_q, digit_d;
  logic                     bad_q, bad_d;
  logic [1:0]               whole_q, whole_d;
  logic [FracBits-1:0]      frac_q, frac_d;
  logic [PlaceIdxWidth-1:0] place_q, place_d;
  logic                     nz_q, nz_d;

  logic                     is_space;
  logic                     is_digit;
  logic [3:0]               dig;
  logic [5:0]               whole_sum;
  logic [PlaceIdxWidth-1:0] place_next;
  logic [FracBits+3:0]      prod;
  logic                     in_body;
  dtfx_phase_e              phase_eff;

  assign is_space   = ((ch_i >= CH_TAB) && (ch_i <= CH_CR)) || (ch_i == CH_SPACE);
  assign is_digit   = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig        = 4'(ch_i - CH_ZERO);
  assign whole_sum  = 6'(whole_q) * 6'd10 + 6'(dig);
  assign place_next = (place_q == '1) ? place_q : place_q + 1'b1;
  assign prod       = {4'b0, weight_tab[place_next]} * {{FracBits{1'b0}}, dig};

  // next phase: leading blanks, then signs, then body
  always_comb begin
    phase_eff = phase_q;
    in_body   = 1'b0;
    unique case (phase_q)
      PH_SPACE: begin
        if (is_space) begin
          phase_eff = PH_SPACE;
        end else if ((ch_i == CH_PLUS) || (ch_i == CH_MINUS)) begin
          phase_eff = PH_SIGN;
        end else begin
          phase_eff = PH_BODY;
          in_body   = 1'b1;
        end
      end
      PH_SIGN: begin
        if ((ch_i == CH_PLUS) || (ch_i == CH_MINUS)) begin
          phase_eff = PH_SIGN;
        end else begin
          phase_eff = PH_BODY;
          in_body   = 1'b1;
        end
      end
      PH_BODY: begin
        phase_eff = PH_BODY;
        in_body   = 1'b1;
      end
      default: begin
        phase_eff = PH_SPACE;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      phase_d = (ch_i == CH_NUL) ? PH_SPACE : phase_eff;
    end
  end

  // accumulator updates
  always_comb begin
    neg_d   = neg_q;
    point_d = point_q;
    digit_d = digit_q;
    bad_d   = bad_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    place_d = place_q;
    nz_d    = nz_q;
    if (step_i) begin
      if (ch_i == CH_NUL) begin
        neg_d   = 1'b0;
        point_d = 1'b0;
        digit_d = 1'b0;
        bad_d   = 1'b0;
        whole_d = '0;
        frac_d  = '0;
        place_d = '0;
        nz_d    = 1'b0;
      end else if (!in_body) begin
        if ((phase_eff == PH_SIGN) && (ch_i == CH_MINUS)) begin
          neg_d = !neg_q;
        end
      end else if (!bad_q) begin
        priority if (ch_i == CH_POINT) begin
          if (point_q) begin
            bad_d = 1'b1;
          end else begin
            point_d = 1'b1;
          end
        end else if (is_digit) begin
          digit_d = 1'b1;
          if (!point_q) begin
            whole_d = (whole_sum > 6'd3) ? 2'd3 : whole_sum[1:0];
          end else begin
            place_d = place_next;
            frac_d  = frac_q + prod[FracBits-1:0];
            if (dig != 4'd0) begin
              nz_d = 1'b1;
            end
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      point_q <= 1'b0;
      digit_q <= 1'b0;
      bad_q   <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      place_q <= '0;
      nz_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      point_q <= point_d;
      digit_q <= digit_d;
      bad_q   <= bad_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      place_q <= place_d;
      nz_q    <= nz_d;
    end
  end

  // final result from the state left by the body
  logic [ValueWidth-1:0] mag;
  assign mag = {1'b0, whole_q, frac_q};

  always_comb begin
    value_o = '0;
    priority if (bad_q) begin
      status_o = ST_BAD_CHAR;
    end else if (!digit_q) begin
      status_o = ST_NO_DIGIT;
    end else if ((whole_q == 2'd3) || ((whole_q == 2'd2) && nz_q)) begin
      status_o = ST_RANGE;
    end else begin
      status_o = ST_OK;
      value_o  = neg_q ? -mag : mag;
    end
  end

endmodule

// ===== hdl/decimal_text_to_fixed_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_unit
// parses a nul-terminated decimal string into a signed fixed-point value
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents                    beats
//  in_i     in   ch: one ascii byte               one per string byte
//  out_o    out  value, status                    one per nul byte
//
//  one byte per cycle sustained unless a nul waits on a full result register;
//  a result is offered once its nul has passed the byte register into the
//  result register; the single accumulator update in dtfx_parse sets the rate
//  reset clears the parser and both valid flags; no memory, no clearing pass
//  a nul waits in the byte register only while the result register is
//  full and not being taken; other bytes keep flowing past a waiting result
//
module decimal_text_to_fixed_point_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtfx_in_if.sink    in_i,
  dtfx_out_if.source out_o
);
  import dtfx_pkg::*;

  localparam int ValueWidth = FRAC_BITS + 3;

  // byte register
  logic       stage_valid_q, stage_valid_d;
  logic [7:0] stage_ch_q;
  logic       stage_nul;
  logic       stage_fire;
  logic       in_fire;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0] out_value_q;
  dtfx_status_e                 out_status_q;
  logic                         out_load;

  // parser result fields
  logic signed [ValueWidth-1:0] res_value;
  dtfx_status_e                 res_status;

  assign stage_nul = (stage_ch_q == CH_NUL);
  // a nul moves on only if the result register is free or draining
  assign stage_fire = stage_valid_q && (!stage_nul || !out_valid_q || out_o.ready);
  assign in_i.ready = !stage_valid_q || stage_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = stage_fire && stage_nul;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_fire) begin
      stage_valid_d = 1'b1;
    end else if (stage_fire) begin
      stage_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_ch_q <= in_i.ch;
    end
    if (out_load) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  dtfx_parse #(
    .FracBits (FRAC_BITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (stage_fire),
    .ch_i     (stage_ch_q),
    .value_o  (res_value),
    .status_o (res_status)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  // a held nul must stall the input side
  a_nul_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && stage_nul && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while a nul waits on a full result register");

  // failed results carry a zero value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> (out_value_q == '0))
    else $error("nonzero value with a failing status");

  // a new result only follows a nul leaving the byte register
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stage_valid_q && stage_nul))
    else $error("result raised without a nul byte");

endmodule
